// ===== design/urld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urld_pkg: shared types and constants for the URL decoder core
// Character codes, decode phases, default sizes, the digit function and the
// job record passed from the decoder to the result emitter.
// ----------------------------------------------------------------------------
package urld_pkg;

  localparam int DEF_MESSAGE_LIMIT = 199;
  localparam int DEF_TEXT_ROWS     = 4;
  localparam int DEF_TEXT_COLUMNS  = 20;

  // Counter widths cover the full parameter ranges (rows up to 15, columns up to 31)
  localparam int ROW_CNT_W = 4;
  localparam int COL_CNT_W = 5;
  localparam int RAW_CNT_W = 8;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;

  typedef enum logic [2:0] {
    PH_PLAIN = 3'b001,
    PH_DIG1  = 3'b010,
    PH_DIG2  = 3'b100
  } urld_phase_t;

  typedef struct packed {
    logic                 char_v;
    logic [ROW_CNT_W-1:0] char_row;
    logic [COL_CNT_W-1:0] char_col;
    logic [7:0]           char_ch;
    logic                 end_v;
    logic [ROW_CNT_W-1:0] end_row;
    logic [COL_CNT_W-1:0] end_col;
  } urld_job_t;

  // Uppercase, then map hex digits to 0..15; anything else keeps its uppercased code
  function automatic logic [7:0] digit_value(input logic [7:0] b);
    logic [7:0] u;
    u = b;
    if (b >= 8'h61 && b <= 8'h7A) begin
      u = b - 8'd32;
    end
    if (u >= 8'h30 && u <= 8'h39) begin
      return u - 8'h30;
    end else if (u >= 8'h41 && u <= 8'h46) begin
      return u - 8'h41 + 8'd10;
    end else begin
      return u;
    end
  endfunction

endpackage

// ===== design/urld_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urld_decode: percent decoder and text cursor
// Holds the decode and cursor state, and turns one raw byte into a job.
// ----------------------------------------------------------------------------
module urld_decode #(
  parameter int MESSAGE_LIMIT = urld_pkg::DEF_MESSAGE_LIMIT,
  parameter int TEXT_ROWS     = urld_pkg::DEF_TEXT_ROWS,
  parameter int TEXT_COLUMNS  = urld_pkg::DEF_TEXT_COLUMNS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [7:0]         raw_byte,
  input  logic               end_of_message,
  output urld_pkg::urld_job_t job
);

  localparam logic [urld_pkg::ROW_CNT_W-1:0] ROWS  = urld_pkg::ROW_CNT_W'(TEXT_ROWS);
  localparam logic [urld_pkg::COL_CNT_W-1:0] COLS  = urld_pkg::COL_CNT_W'(TEXT_COLUMNS);
  localparam logic [urld_pkg::RAW_CNT_W-1:0] LIMIT = urld_pkg::RAW_CNT_W'(MESSAGE_LIMIT);

  urld_pkg::urld_phase_t            phase_r, phase_nxt;
  logic [3:0]                       hi_r, hi_nxt;
  logic [urld_pkg::ROW_CNT_W-1:0]   row_r, row_nxt, row_mid;
  logic [urld_pkg::COL_CNT_W-1:0]   col_r, col_nxt, col_mid;
  logic [urld_pkg::RAW_CNT_W-1:0]   raw_r, raw_nxt;
  logic                             ended_r, ended_nxt;
  logic [7:0]                       dv;
  logic [7:0]                       esc_val;
  logic                             lay_v;
  logic [7:0]                       lay_ch;

  always_comb begin
    dv        = urld_pkg::digit_value(raw_byte);
    esc_val   = {hi_r, 4'h0} + dv;
    phase_nxt = phase_r;
    hi_nxt    = hi_r;
    raw_nxt   = raw_r;
    ended_nxt = ended_r;
    lay_v     = 1'b0;
    lay_ch    = raw_byte;
    row_mid   = row_r;
    col_mid   = col_r;
    job       = '0;

    if (!ended_r) begin
      if (raw_r >= LIMIT) begin
        // A pending escape at the limit ends the string
        if (phase_r != urld_pkg::PH_PLAIN) begin
          ended_nxt = 1'b1;
        end
        phase_nxt = urld_pkg::PH_PLAIN;
      end else begin
        raw_nxt = raw_r + 1'b1;
        if (raw_byte == urld_pkg::CH_NUL) begin
          ended_nxt = 1'b1;
          phase_nxt = urld_pkg::PH_PLAIN;
        end else begin
          case (phase_r)
            urld_pkg::PH_PLAIN: begin
              if (raw_byte == urld_pkg::CH_PLUS) begin
                lay_v  = 1'b1;
                lay_ch = urld_pkg::CH_SPACE;
              end else if (raw_byte == urld_pkg::CH_PERCENT) begin
                phase_nxt = urld_pkg::PH_DIG1;
              end else begin
                lay_v = 1'b1;
              end
            end
            urld_pkg::PH_DIG1: begin
              hi_nxt    = dv[3:0];
              phase_nxt = urld_pkg::PH_DIG2;
            end
            urld_pkg::PH_DIG2: begin
              phase_nxt = urld_pkg::PH_PLAIN;
              if (esc_val == urld_pkg::CH_NUL) begin
                ended_nxt = 1'b1;
              end else begin
                lay_v  = 1'b1;
                lay_ch = esc_val;
              end
            end
            default: begin
              phase_nxt = urld_pkg::PH_PLAIN;
            end
          endcase
        end
      end
    end

    // Lay the decoded character into the text store
    if (lay_v && lay_ch != urld_pkg::CH_CR && row_r < ROWS) begin
      job.char_v   = 1'b1;
      job.char_row = row_r;
      job.char_col = col_r;
      if (lay_ch == urld_pkg::CH_LF) begin
        job.char_ch = urld_pkg::CH_NUL;
        row_mid     = row_r + 1'b1;
        col_mid     = '0;
      end else if (col_r < COLS) begin
        job.char_ch = lay_ch;
        col_mid     = col_r + 1'b1;
      end else begin
        job.char_ch = urld_pkg::CH_NUL;
      end
    end

    row_nxt = row_mid;
    col_nxt = col_mid;

    if (end_of_message) begin
      job.end_v   = 1'b1;
      job.end_row = row_mid;
      job.end_col = col_mid;
      phase_nxt   = urld_pkg::PH_PLAIN;
      hi_nxt      = '0;
      row_nxt     = '0;
      col_nxt     = '0;
      raw_nxt     = '0;
      ended_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= urld_pkg::PH_PLAIN;
      hi_r    <= '0;
      row_r   <= '0;
      col_r   <= '0;
      raw_r   <= '0;
      ended_r <= 1'b0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      hi_r    <= hi_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      raw_r   <= raw_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

// ===== design/urld_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urld_emit: job register and result register
// Holds one job and hands out its results one per cycle into the output while the output is not stalled.
// ----------------------------------------------------------------------------
module urld_emit #(
  parameter int TEXT_ROWS = urld_pkg::DEF_TEXT_ROWS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  urld_pkg::urld_job_t job_in,
  output logic                job_ready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,
  output logic                out_tuser,
  output logic                out_tlast
);

  localparam logic [urld_pkg::ROW_CNT_W-1:0] ROWS = urld_pkg::ROW_CNT_W'(TEXT_ROWS);

  urld_pkg::urld_job_t job_r, job_nxt;
  logic                first_r, first_nxt;
  logic                busy, move, last_of_job;
  logic [1:0]          res_row;
  logic [4:0]          res_col;
  logic [7:0]          res_ch;
  logic                res_we, res_done;
  logic                out_v_r;
  logic [1:0]          out_row_r;
  logic [4:0]          out_col_r;
  logic [7:0]          out_ch_r;
  logic                out_we_r, out_done_r;

  always_comb begin
    busy        = job_r.char_v | job_r.end_v;
    res_row     = job_r.char_row[1:0];
    res_col     = job_r.char_col;
    res_ch      = job_r.char_ch;
    res_we      = 1'b1;
    res_done    = 1'b0;
    last_of_job = !job_r.end_v;
    if (!job_r.char_v) begin
      res_ch = urld_pkg::CH_NUL;
      if (job_r.end_row >= ROWS) begin
        // No row left to write: plain done marker
        res_row  = '0;
        res_col  = '0;
        res_we   = 1'b0;
        res_done = 1'b1;
      end else begin
        res_row  = job_r.end_row[1:0];
        res_col  = first_r ? job_r.end_col : '0;
        res_done = (job_r.end_row == ROWS - 1'b1);
      end
      last_of_job = res_done;
    end
    move      = busy && (!out_v_r || out_tready);
    job_ready = !busy || (move && last_of_job);

    job_nxt   = job_r;
    first_nxt = first_r;
    if (in_fire) begin
      job_nxt   = job_in;
      first_nxt = 1'b1;
    end else if (move) begin
      if (job_r.char_v) begin
        job_nxt.char_v = 1'b0;
      end else begin
        job_nxt.end_row = job_r.end_row + 1'b1;
        first_nxt       = 1'b0;
        if (res_done) begin
          job_nxt.end_v = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r   <= '0;
      first_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      job_r   <= job_nxt;
      first_r <= first_nxt;
      if (move) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_row_r  <= res_row;
      out_col_r  <= res_col;
      out_ch_r   <= res_ch;
      out_we_r   <= res_we;
      out_done_r <= res_done;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_ch_r, out_col_r, out_row_r};
  assign out_tuser  = out_we_r;
  assign out_tlast  = out_done_r;

endmodule

// ===== design/url_decode_to_text_lines_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_decode_to_text_lines_core: URL decoder feeding a text row store
// Decodes URL-encoded bytes and emits write commands for a rows-by-columns
// character store, with an end-of-message clean-up sequence.
// ----------------------------------------------------------------------------
// Feed one encoded byte per item on the in_ stream; mark the final byte of a
// message with in_tlast. A '+' turns into a space, '%' plus two digits into
// one byte, CR is skipped, LF terminates the row and moves to the next one,
// and characters past the last column write a terminator into the terminator
// slot. A zero byte (raw or decoded) or the byte limit ends the string; later
// bytes of that message only count toward in_tlast. On the last byte the
// current row is terminated, the rows below it are cleared, and the final
// result carries out_tlast; out_tuser low means a done marker with no write.
// Timing: while the output is not stalled, an item yielding zero or one
// result is taken every cycle; one yielding more holds the input until its
// last result moves on, as the job register hands out one result per cycle
// into the output register. Results pass the job register, then the output
// register. With four rows an item gives at most five results.
// ----------------------------------------------------------------------------
module url_decode_to_text_lines_core #(
  parameter int MESSAGE_LIMIT = urld_pkg::DEF_MESSAGE_LIMIT,
  parameter int TEXT_ROWS     = urld_pkg::DEF_TEXT_ROWS,
  parameter int TEXT_COLUMNS  = urld_pkg::DEF_TEXT_COLUMNS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] raw_byte
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] row, [6:2] column, [14:7] character, [15] zero
  output logic        out_tuser,  // write_enable
  output logic        out_tlast   // message_done
);

  urld_pkg::urld_job_t job;
  logic                in_fire;

  // Accept an item whenever the job register is empty or empties this cycle
  assign in_fire = in_tvalid & in_tready;

  urld_decode #(
    .MESSAGE_LIMIT (MESSAGE_LIMIT),
    .TEXT_ROWS     (TEXT_ROWS),
    .TEXT_COLUMNS  (TEXT_COLUMNS)
  ) u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .raw_byte       (in_tdata),
    .end_of_message (in_tlast),
    .job            (job)
  );

  urld_emit #(
    .TEXT_ROWS (TEXT_ROWS)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .job_in     (job),
    .job_ready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== design/urld_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urld_checker: port-level checks for the URL decoder core
// Watches the result stream for reset, hold and field consistency.
// ----------------------------------------------------------------------------
module urld_checker #(
  parameter int TEXT_COLUMNS = urld_pkg::DEF_TEXT_COLUMNS
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_marker_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && out_tdata == 16'h0000)
    else $error("non-write result is not a clean done marker");

  a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6:2] <= 5'(TEXT_COLUMNS))
    else $error("column past terminator slot");

endmodule

bind url_decode_to_text_lines_core urld_checker #(
  .TEXT_COLUMNS (TEXT_COLUMNS)
) u_urld_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
